### rtl/core/sis_pkg.sv
// Shared constants and controller/datapath interface types for the signed integer sorter.
`default_nettype none
package sis_pkg;
    localparam int Capacity = 64;
    localparam int IdxW = $clog2(Capacity);
    localparam int CntW = $clog2(Capacity + 1);
    localparam int DataW = 32;

    typedef struct packed {
        logic load;    // insert value into the sorted chain
        logic drop;    // note a dropped item
        logic shift;   // move the chain one slot toward the output
        logic clear;   // restart for a new list
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic one_left;
        logic dropped;
    } stat_t;
endpackage
`default_nettype wire

### rtl/core/sis_datapath.sv
// Systolic insertion chain holding the list in ascending order, with fill count and drop flag.
`default_nettype none
module sis_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sis_pkg::cmd_t                 cmd,
    input  wire logic signed [sis_pkg::DataW-1:0] value,
    output logic signed [sis_pkg::DataW-1:0]   head,
    output sis_pkg::stat_t                     stat
);
    logic signed [sis_pkg::DataW-1:0] cell_reg [sis_pkg::Capacity];
    logic signed [sis_pkg::DataW-1:0] cell_next [sis_pkg::Capacity];
    logic [sis_pkg::CntW-1:0] count_reg, count_next;
    logic dropped_reg, dropped_next;
    logic [sis_pkg::Capacity-1:0] gt;

    // Each cell compares against the new item alone; the chain stays sorted so the
    // greater-than flags form a thermometer code.
    always_comb
    begin
        for (int i = 0; i < sis_pkg::Capacity; i++)
        begin
            gt[i] = (sis_pkg::CntW'(i) < count_reg) && (cell_reg[i] > value);
            cell_next[i] = cell_reg[i];
            if (cmd.load)
            begin
                if (i == 0)
                begin
                    if (gt[0] || count_reg == '0)
                        cell_next[0] = value;
                end
                else if (gt[i-1])
                    cell_next[i] = cell_reg[i-1];
                else if (gt[i] || sis_pkg::CntW'(i) == count_reg)
                    cell_next[i] = value;
            end
            else if (cmd.shift && i < sis_pkg::Capacity - 1)
                cell_next[i] = cell_reg[i+1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < sis_pkg::Capacity; i++)
            cell_reg[i] <= cell_next[i];
    end

    always_comb
    begin
        count_next = count_reg;
        dropped_next = dropped_reg;
        if (cmd.clear)
        begin
            count_next = '0;
            dropped_next = 1'b0;
        end
        else if (cmd.load)
            count_next = count_reg + 1'b1;
        else if (cmd.shift)
            count_next = count_reg - 1'b1;
        if (cmd.drop)
            dropped_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    assign head = cell_reg[0];
    assign stat.full = (count_reg == sis_pkg::CntW'(sis_pkg::Capacity));
    assign stat.empty = (count_reg == '0);
    assign stat.one_left = (count_reg == sis_pkg::CntW'(1));
    assign stat.dropped = dropped_reg;
endmodule
`default_nettype wire

### rtl/core/sis_ctrl.sv
// Controller: load phase, then drain phase through a registered output stage.
`default_nettype none
module sis_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           is_last,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic                last_out,
    output logic                overflow,
    output logic                capture,
    input  wire sis_pkg::stat_t stat,
    output sis_pkg::cmd_t       cmd
);
    typedef enum logic [0:0] {LOAD, DRAIN} state_t;
    state_t state_reg;
    logic out_free, accept;

    assign out_free = !out_valid || out_ready;
    assign in_ready = (state_reg == LOAD);
    assign accept = in_valid && in_ready;
    // An output slot opens whenever the holding register is empty or being taken.
    assign capture = (state_reg == DRAIN) && out_free && !stat.empty;

    always_comb
    begin
        cmd = '0;
        cmd.load = accept && !stat.full;
        cmd.drop = accept && stat.full;
        cmd.shift = capture;
        cmd.clear = capture && stat.one_left;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LOAD;
            out_valid <= 1'b0;
            last_out <= 1'b0;
            overflow <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            unique case (state_reg)
                LOAD:
                begin
                    if (accept && is_last)
                        state_reg <= DRAIN;
                end
                DRAIN:
                begin
                    if (capture)
                    begin
                        out_valid <= 1'b1;
                        last_out <= stat.one_left;
                        overflow <= stat.dropped;
                        if (stat.one_left)
                            state_reg <= LOAD;
                    end
                end
                default: state_reg <= LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/core/signed_int_sorter.sv
// Top level of the signed integer sorter.
// Items enter one per cycle while a list loads; each is placed into a 64-cell
// systolic insertion chain in the same cycle. After the item marked last, the
// list leaves in ascending signed order, one item per cycle through a registered
// output stage, while no new input is taken. The first result is offered once the
// controller has entered its drain state and captured the chain head into the
// output register. The input is not ready during the drain, and output stalls
// stretch the drain. Items beyond 64 are dropped and every result of that list
// carries overflow.
`default_nettype none
module signed_int_sorter (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] value,
    input  wire logic               is_last,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      sorted_value,
    output logic                    last_out,
    output logic                    overflow
);
    sis_pkg::cmd_t cmd;
    sis_pkg::stat_t stat;
    logic signed [31:0] head;
    logic capture;
    logic signed [31:0] data_reg;

    sis_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .value(value), .head(head), .stat(stat)
    );

    sis_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .is_last(is_last),
        .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
        .last_out(last_out), .overflow(overflow), .capture(capture),
        .stat(stat), .cmd(cmd)
    );

    always_ff @(posedge clk)
    begin
        if (capture)
            data_reg <= head;
    end
    assign sorted_value = data_reg;

    a_no_load_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && stat.full)) else $error("load into full chain");
    a_no_input_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && capture)) else $error("load and drain overlap");
    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (capture && stat.one_left) |=> stat.empty) else $error("chain not empty after last");
endmodule
`default_nettype wire

### sim/sorter_checker.sv
// Checker for the signed integer sorter: watches both channels, predicts the sorted lists.
module sorter_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic signed [31:0] value,
    input  wire logic               is_last,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [31:0] sorted_value,
    input  wire logic               last_out,
    input  wire logic               overflow,
    output int                      fail_count,
    output int                      pending,
    output int                      results_seen,
    output int                      lists_seen,
    output int                      overflow_lists
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] val;
        logic               last;
        logic               ovf;
    } sorted_item_t;

    logic signed [31:0] list_store[$];
    logic               dropped;
    sorted_item_t       sorted_queue[$];

    // Keeps the list in ascending signed order; emits it once the last item arrives.
    task automatic take_element(input logic signed [31:0] v, input logic lst);
        int pos;
        sorted_item_t r;
        if (list_store.size() < sis_pkg::Capacity)
        begin
            pos = list_store.size();
            while (pos > 0 && list_store[pos - 1] > v)
                pos--;
            list_store.insert(pos, v);
        end
        else
            dropped = 1'b1;
        if (lst)
        begin
            foreach (list_store[k])
            begin
                r.val = list_store[k];
                r.last = (k == list_store.size() - 1);
                r.ovf = dropped;
                sorted_queue.push_back(r);
            end
            lists_seen++;
            if (dropped)
                overflow_lists++;
            list_store.delete();
            dropped = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sorted_item_t e;
        if (!rst_n)
        begin
            list_store.delete();
            sorted_queue.delete();
            dropped = 1'b0;
            pending = 0;
            fail_count <= 0;
            results_seen <= 0;
            lists_seen = 0;
            overflow_lists = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (sorted_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result value=%0d last=%b ovf=%b",
                                 sorted_value, last_out, overflow);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = sorted_queue.pop_front();
                    if (e.val !== sorted_value || e.last !== last_out
                        || e.ovf !== overflow)
                    begin
                        if (fail_count < 10)
                            $display("ERROR: expected %0d/%b/%b got %0d/%b/%b",
                                     e.val, e.last, e.ovf,
                                     sorted_value, last_out, overflow);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                take_element(value, is_last);
            pending = sorted_queue.size();
        end
    end
endmodule

### sim/tb_top.sv
// Testbench top for the signed integer sorter: stimulus, idling phases and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 20000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] value = '0;
    logic               is_last = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] sorted_value;
    logic               last_out;
    logic               overflow;

    int fail_count, pending, results_seen, lists_seen, overflow_lists;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    int items_sent = 0;
    int idle_cycles = 0;

    always #4 clk = ~clk;

    signed_int_sorter i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .value(value), .is_last(is_last),
        .out_valid(out_valid), .out_ready(out_ready),
        .sorted_value(sorted_value), .last_out(last_out), .overflow(overflow)
    );

    sorter_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .value(value), .is_last(is_last),
        .out_valid(out_valid), .out_ready(out_ready),
        .sorted_value(sorted_value), .last_out(last_out), .overflow(overflow),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen),
        .lists_seen(lists_seen), .overflow_lists(overflow_lists)
    );

    // Receiver: random stalls, or a full hold-off while hold_off is set.
    always @(posedge clk)
        out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("watchdog: no item moved for %0d cycles", WatchdogLimit);
            $display("signed_int_sorter verification failed");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'sh8000_0000 + $urandom_range(3);
            1: return 32'sh7fff_ffff - $urandom_range(3);
            2: return $urandom_range(8) - 4;
            default: return $urandom;
        endcase
    endfunction

    // Offers one item and holds it until it is accepted. Valid stays high after
    // acceptance so that a following item can go back to back; it drops only
    // when the sender idles.
    task automatic offer_item(input logic signed [31:0] v, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        is_last <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_list(input int len);
        for (int k = 0; k < len; k++)
            offer_item(pick_value(), k == len - 1);
    endtask

    // The sender stops offering and waits until every expected result is back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int n;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single item, extremes, duplicates, exact capacity, overflow.
        offer_item(32'sh8000_0000, 1'b1);
        offer_item(32'sh7fff_ffff, 1'b0);
        offer_item(32'sh8000_0000, 1'b0);
        offer_item(32'sh0000_0000, 1'b0);
        offer_item(-32'sd1, 1'b0);
        offer_item(32'sh5555_5555, 1'b0);
        offer_item(32'shaaaa_aaaa, 1'b0);
        offer_item(-32'sd1, 1'b1);
        offer_item(32'sd7, 1'b0);
        offer_item(32'sd7, 1'b0);
        offer_item(32'sd7, 1'b1);
        drain_results();
        send_list(64);
        send_list(66);
        drain_results();

        // Long receiver hold-off; the second list keeps offering while the block stalls.
        hold_off = 1'b1;
        fork
            begin
                send_list(20);
                send_list(5);
            end
            begin
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
        join
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 64 : 28) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 64 : 28) : 0;
            for (int l = 0; l < 3; l++)
            begin
                case ($urandom_range(9))
                    0: n = 1;
                    default: n = $urandom_range(8, 2);
                endcase
                send_list(n);
            end
            // Sender pauses until all results of this phase are back.
            drain_results();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        drain_results();
        repeat (20) @(posedge clk);
        $display("Sent %0d items in %0d lists (%0d overflowed), checked %0d results.",
                 items_sent, lists_seen, overflow_lists, results_seen);
        if (fail_count == 0 && pending == 0)
            $display("signed_int_sorter verification clean");
        else
            $display("signed_int_sorter verification failed");
        $finish;
    end
endmodule

### signed_int_sorter.f
rtl/core/sis_pkg.sv
rtl/core/sis_datapath.sv
rtl/core/sis_ctrl.sv
rtl/core/signed_int_sorter.sv
sim/sorter_checker.sv
sim/tb_top.sv
